[hw/rtl/scau_pkg.sv]
package scau_pkg;

  // Operand and result widths
  localparam int ANGLE_BITS   = 16;
  localparam int RATIO_BITS   = 15;
  localparam int RESULT_BITS  = 15;

  // Range reduction: one conditional subtract of 3600 << k per cycle, k high to low.
  // The angle magnitude fits ANGLE_BITS bits, so ANGLE_BITS - 11 steps suffice.
  localparam int RED_STEPS    = ANGLE_BITS - 11;
  localparam int RED_CNT_BITS = $clog2(RED_STEPS);

  // Angle constants, tenths of a degree
  localparam logic [ANGLE_BITS-1:0] TURN_ANGLE = ANGLE_BITS'(3600);
  localparam logic [11:0] TURN_12     = 12'd3600;
  localparam logic [11:0] THREE_QTR   = 12'd2700;
  localparam logic [11:0] HALF_TURN   = 12'd1800;
  localparam logic [11:0] QTR_TURN    = 12'd900;
  localparam logic [9:0]  SEARCH_HI   = 10'd900;
  localparam logic [9:0]  SEARCH_MID  = 10'd450;

  // x / 10 as (x * 205) >> 11, exact for x below 1029
  localparam logic [17:0] DIV10_MUL   = 18'd205;
  localparam int          DIV10_SHIFT = 11;

  // (n + 286) / 573 as ((n + 286) * 234237) >> 27, exact while n + 286 fits 17 bits
  localparam logic [16:0] INTERP_RND  = 17'd286;
  localparam logic [34:0] RECIP_573   = 35'd234237;
  localparam int          RECIP_SHIFT = 27;

  // Ratio clamp
  localparam logic signed [RATIO_BITS-1:0] RATIO_MAX = RATIO_BITS'(10000);
  localparam logic signed [RATIO_BITS-1:0] RATIO_MIN = -RATIO_BITS'(10000);

  typedef enum logic [1:0] {
    CMD_SIN  = 2'd0,
    CMD_COS  = 2'd1,
    CMD_ASIN = 2'd2,
    CMD_ACOS = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FOLD,
    ST_DIV10,
    ST_MULT,
    ST_RECIP,
    ST_SUM,
    ST_ROUND,
    ST_EMIT
  } state_e;

  // Cosine in whole degrees, scaled by 10000
  localparam logic [13:0] COS_TAB [91] = '{
    14'd10000, 14'd9998, 14'd9994, 14'd9986, 14'd9976, 14'd9962, 14'd9945, 14'd9925,
    14'd9903,  14'd9877, 14'd9848, 14'd9816, 14'd9781, 14'd9744, 14'd9703, 14'd9659,
    14'd9613,  14'd9563, 14'd9511, 14'd9455, 14'd9397, 14'd9336, 14'd9272, 14'd9205,
    14'd9135,  14'd9063, 14'd8988, 14'd8910, 14'd8829, 14'd8746, 14'd8660, 14'd8572,
    14'd8480,  14'd8387, 14'd8290, 14'd8192, 14'd8090, 14'd7986, 14'd7880, 14'd7771,
    14'd7660,  14'd7547, 14'd7431, 14'd7314, 14'd7193, 14'd7071, 14'd6947, 14'd6820,
    14'd6691,  14'd6561, 14'd6428, 14'd6293, 14'd6157, 14'd6018, 14'd5878, 14'd5736,
    14'd5592,  14'd5446, 14'd5299, 14'd5150, 14'd5000, 14'd4848, 14'd4695, 14'd4540,
    14'd4384,  14'd4226, 14'd4067, 14'd3907, 14'd3746, 14'd3584, 14'd3420, 14'd3256,
    14'd3090,  14'd2924, 14'd2756, 14'd2588, 14'd2419, 14'd2250, 14'd2079, 14'd1908,
    14'd1736,  14'd1564, 14'd1392, 14'd1219, 14'd1045, 14'd872,  14'd698,  14'd523,
    14'd349,   14'd175,  14'd0
  };

  function automatic logic [13:0] cos_lookup(input logic [6:0] deg);
    logic [13:0] val;
    if (deg > 7'd90) begin
      val = '0;
    end else begin
      val = COS_TAB[deg];
    end
    return val;
  endfunction

endpackage

[hw/rtl/sine_cosine_arcsine_unit_core.sv]
// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_stall_o    command_i, angle_i, ratio_i
// result    out        out_valid_o / out_stall_i  result_o
//
// Sine and cosine: five conditional subtracts of the modulo-3600 reduction, then the
//   table datapath states FOLD, DIV10, MULT, RECIP and SUM, then the output state EMIT.
// Arcsine and arccosine: up to 11 search probes, each through the same datapath states,
//   then rounding and output.
// One request at a time; in_stall_o is high from accept until the result enters the
//   output register. A waiting result does not block the next request.
// Reset clears the sequencer and the output valid; no clearing pass.
module sine_cosine_arcsine_unit_core
  import scau_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic signed [ANGLE_BITS-1:0]  angle_i,
  input  logic signed [RATIO_BITS-1:0]  ratio_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [RESULT_BITS-1:0] result_o
);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;

  logic [ANGLE_BITS-1:0]   rem_q, rem_d;
  logic                    xneg_q, xneg_d;
  logic [RED_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [9:0]              a_q, a_d;
  logic                    sneg_q, sneg_d;
  logic [6:0]              deg_q, deg_d;
  logic [3:0]              frac_q, frac_d;
  logic [16:0]             prod_q, prod_d;
  logic [13:0]             base_q, base_d;
  logic [7:0]              quo_q, quo_d;
  logic [13:0]             v_q, v_d;
  logic                    rneg_q, rneg_d;
  logic [9:0]              lo_q, lo_d, hi_q, hi_d, step_q, step_d, idx_q, idx_d;
  logic signed [RESULT_BITS-1:0] res_q, res_d;
  logic signed [RESULT_BITS-1:0] result_q, result_d;
  logic                    out_valid_q, out_valid_d;

  logic        in_accept;
  cmd_e        in_cmd;

  // Request decode: operand for sine/cosine, clamped ratio for the search
  logic signed [ANGLE_BITS:0]   angle_ext, x_sel;
  logic [ANGLE_BITS:0]          x_abs;
  logic signed [RATIO_BITS-1:0] ratio_clamp, ratio_abs;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_cmd    = cmd_e'(command_i);
  assign angle_ext = {angle_i[ANGLE_BITS-1], angle_i};
  assign x_sel     = (in_cmd == CMD_SIN) ? angle_ext
                                         : ((ANGLE_BITS+1)'(900) - angle_ext);
  assign x_abs     = x_sel[ANGLE_BITS] ? (ANGLE_BITS+1)'(-x_sel)
                                       : (ANGLE_BITS+1)'(x_sel);

  always_comb begin
    priority if (ratio_i > RATIO_MAX) begin
      ratio_clamp = RATIO_MAX;
    end else if (ratio_i < RATIO_MIN) begin
      ratio_clamp = RATIO_MIN;
    end else begin
      ratio_clamp = ratio_i;
    end
  end
  assign ratio_abs = ratio_clamp[RATIO_BITS-1] ? -ratio_clamp : ratio_clamp;

  // Reduction step
  logic [ANGLE_BITS-1:0] red_sub;
  logic                  red_ge;
  assign red_sub = TURN_ANGLE << cnt_q;
  assign red_ge  = rem_q >= red_sub;

  // Fold into the first quadrant
  logic [11:0] turn;
  logic [9:0]  fold_a;
  logic        fold_neg;
  assign turn = (xneg_q && (rem_q[11:0] != 12'd0)) ? (TURN_12 - rem_q[11:0]) : rem_q[11:0];

  always_comb begin
    fold_neg = turn > HALF_TURN;
    priority if (turn > THREE_QTR) begin
      fold_a = 10'(TURN_12 - turn);
    end else if (turn > HALF_TURN) begin
      fold_a = 10'(turn - HALF_TURN);
    end else if (turn > QTR_TURN) begin
      fold_a = 10'(HALF_TURN - turn);
    end else begin
      fold_a = turn[9:0];
    end
  end

  // Whole degrees and tenths
  logic [17:0] a_x205;
  logic [6:0]  deg_calc;
  logic [9:0]  frac_full;
  assign a_x205    = 18'(a_q) * DIV10_MUL;
  assign deg_calc  = a_x205[DIV10_SHIFT+6:DIV10_SHIFT];
  assign frac_full = a_q - (10'(deg_calc) * 10'd10);

  // Interpolation product and rounded divide by 573
  logic [17:0] prod_full;
  logic [16:0] recip_num;
  logic [34:0] recip_full;
  assign prod_full  = 18'(frac_q) * 18'(cos_lookup(deg_q));
  assign recip_num  = prod_q + INTERP_RND;
  assign recip_full = 35'(recip_num) * RECIP_573;

  // Sum and sign
  logic [13:0]                   mag;
  logic signed [RESULT_BITS-1:0] sine_val;
  assign mag      = base_q + 14'(quo_q);
  assign sine_val = sneg_q ? -RESULT_BITS'(mag) : RESULT_BITS'(mag);

  // Binary search update
  logic       go_low;
  logic [9:0] lo_n, hi_n, span, step_n, idx_n;
  assign go_low = v_q < mag;
  assign lo_n   = go_low ? lo_q : idx_q;
  assign hi_n   = go_low ? idx_q : hi_q;
  assign span   = hi_n - lo_n;
  assign step_n = {1'b0, span[9:1]};
  assign idx_n  = lo_n + step_n;

  // Round the found angle to whole degrees
  logic [9:0]                    rnd_sum;
  logic [17:0]                   rnd_full;
  logic [6:0]                    rnd_deg;
  logic signed [RESULT_BITS-1:0] asin_val, round_val;
  assign rnd_sum   = idx_q + 10'd4;
  assign rnd_full  = 18'(rnd_sum) * DIV10_MUL;
  assign rnd_deg   = rnd_full[DIV10_SHIFT+6:DIV10_SHIFT];
  assign asin_val  = rneg_q ? -RESULT_BITS'(rnd_deg) : RESULT_BITS'(rnd_deg);
  assign round_val = (cmd_q == CMD_ASIN) ? asin_val : (RESULT_BITS'(90) - asin_val);

  // Sequencer: next state and datapath loads
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rem_d       = rem_q;
    xneg_d      = xneg_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    sneg_d      = sneg_q;
    deg_d       = deg_q;
    frac_d      = frac_q;
    prod_d      = prod_q;
    base_d      = base_q;
    quo_d       = quo_q;
    v_d         = v_q;
    rneg_d      = rneg_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    step_d      = step_q;
    idx_d       = idx_q;
    res_d       = res_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d = in_cmd;
          if (in_cmd == CMD_SIN || in_cmd == CMD_COS) begin
            rem_d   = x_abs[ANGLE_BITS-1:0];
            xneg_d  = x_sel[ANGLE_BITS];
            cnt_d   = RED_CNT_BITS'(RED_STEPS - 1);
            state_d = ST_REDUCE;
          end else begin
            v_d     = ratio_abs[13:0];
            rneg_d  = ratio_clamp[RATIO_BITS-1];
            lo_d    = '0;
            hi_d    = SEARCH_HI;
            step_d  = SEARCH_MID;
            idx_d   = SEARCH_MID;
            rem_d   = ANGLE_BITS'(SEARCH_MID);
            xneg_d  = 1'b0;
            state_d = ST_FOLD;
          end
        end
      end
      ST_REDUCE: begin
        if (red_ge) begin
          rem_d = rem_q - red_sub;
        end
        if (cnt_q == '0) begin
          state_d = ST_FOLD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FOLD: begin
        a_d     = fold_a;
        sneg_d  = fold_neg;
        state_d = ST_DIV10;
      end
      ST_DIV10: begin
        deg_d   = deg_calc;
        frac_d  = frac_full[3:0];
        state_d = ST_MULT;
      end
      ST_MULT: begin
        prod_d  = prod_full[16:0];
        base_d  = cos_lookup(7'd90 - deg_q);
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        quo_d   = recip_full[RECIP_SHIFT+7:RECIP_SHIFT];
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (cmd_q == CMD_SIN || cmd_q == CMD_COS) begin
          res_d   = sine_val;
          state_d = ST_EMIT;
        end else if (step_q == '0 || v_q == mag) begin
          state_d = ST_ROUND;
        end else begin
          lo_d    = lo_n;
          hi_d    = hi_n;
          step_d  = step_n;
          idx_d   = idx_n;
          rem_d   = ANGLE_BITS'(idx_n);
          state_d = ST_FOLD;
        end
      end
      ST_ROUND: begin
        res_d   = round_val;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          result_d    = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rem_q    <= rem_d;
    xneg_q   <= xneg_d;
    cnt_q    <= cnt_d;
    a_q      <= a_d;
    sneg_q   <= sneg_d;
    deg_q    <= deg_d;
    frac_q   <= frac_d;
    prod_q   <= prod_d;
    base_q   <= base_d;
    quo_q    <= quo_d;
    v_q      <= v_d;
    rneg_q   <= rneg_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    step_q   <= step_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
    result_q <= result_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

[hw/rtl/scau_checker.sv]
module scau_checker
  import scau_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    command_i,
  input logic signed [ANGLE_BITS-1:0]  angle_i,
  input logic signed [RATIO_BITS-1:0]  ratio_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [RESULT_BITS-1:0] result_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // A new result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  // Result range
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_o >= -15'sd10001) && (result_o <= 15'sd10001))
    else $error("result out of range");

endmodule

bind sine_cosine_arcsine_unit_core scau_checker u_scau_checker (.*);
